@@ rtl/core/rdas_pkg.sv @@
// Package: shared constants and types for the receive dedup / ack scheduler.
package rdas_pkg;
	localparam int HIST_DEPTH_DEF = 8;
	localparam logic [1:0] FUNC_PKT  = 2'd0;
	localparam logic [1:0] FUNC_PERR = 2'd1;
	localparam logic [1:0] FUNC_TICK = 2'd2;
	localparam logic [1:0] ST_STANDBY = 2'd0;
	localparam logic [1:0] ST_RECEIVING = 2'd1;
	localparam logic [1:0] ST_ACKING = 2'd2;
	localparam logic [1:0] ST_ERROR = 2'd3;
	localparam logic [3:0] EV_NONE = 4'd0;
	localparam logic [3:0] EV_ACCEPTED = 4'd1;
	localparam logic [3:0] EV_DUPLICATE = 4'd2;
	localparam logic [3:0] EV_BAD_ID = 4'd3;
	localparam logic [3:0] EV_BAD_FLAGS = 4'd4;
	localparam logic [3:0] EV_PARSE_INV = 4'd5;
	localparam logic [3:0] EV_ACK_SENT = 4'd6;
	localparam logic [3:0] EV_AUX_FAIL = 4'd7;
	localparam logic [3:0] EV_SHORT_WR = 4'd8;
	localparam logic [3:0] EV_ACK_DONE = 4'd9;
	localparam logic [3:0] EV_TX_TIMEOUT = 4'd10;
	localparam logic [2:0] REG_NODE = 3'd0;
	localparam logic [2:0] REG_FLAGS = 3'd1;
	localparam logic [2:0] REG_RXDISP = 3'd2;
	localparam logic [2:0] REG_ACKDISP = 3'd3;
	localparam logic [2:0] REG_ERRDISP = 3'd4;
	localparam logic [2:0] REG_TXMIN = 3'd5;
	localparam logic [2:0] REG_TXTMO = 3'd6;
	localparam logic [2:0] REG_AUXST = 3'd7;
	typedef struct packed {
		logic [15:0] expected_node_id;
		logic [7:0]  known_flags_mask;
		logic [15:0] rx_hold_ms;
		logic [15:0] ack_hold_ms;
		logic [15:0] err_hold_ms;
		logic [15:0] tx_min_ms;
		logic [15:0] tx_limit_ms;
		logic [15:0] aux_settle_ms;
	} cfg_t;
	typedef struct packed {
		logic [1:0]  func;
		logic [31:0] now;
		logic [15:0] node_id;
		logic [31:0] message_id;
		logic [7:0]  valid_flags;
		logic        aux_high;
		logic        tx_complete;
	} item_t;
	typedef struct packed {
		logic [1:0]  link_status;
		logic [3:0]  event_res;
		logic        ack_send;
		logic [15:0] ack_node_id;
		logic [31:0] ack_message_id;
		logic        ack_is_duplicate;
		logic        telemetry_new;
		logic        node_known;
	} res_t;
	function automatic logic reached(input logic [31:0] now, input logic [31:0] dl);
		logic [31:0] d;
		d = now - dl;
		return !d[31];
	endfunction
endpackage

@@ rtl/core/rx_dedup_ack_scheduler.sv @@
// Top level: receive dedup and acknowledgement scheduler.
// A well-formed packet has its result valid only after the history search
// (one memory read per history entry); other items finish without a search.
// One transaction at a time: the next is accepted the cycle after the
// result is taken.
// Reset: arst_n clears all control state, history valid bits; cfg takes defaults.
module rx_dedup_ack_scheduler #(
	parameter int HISTORY_DEPTH = rdas_pkg::HIST_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  func,
	input  logic [31:0] now,
	input  logic [15:0] node_id,
	input  logic [31:0] message_id,
	input  logic [7:0]  valid_flags,
	input  logic        aux_high,
	input  logic        tx_complete,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  link_status,
	output logic [3:0]  event_res,
	output logic        ack_send,
	output logic [15:0] ack_node_id,
	output logic [31:0] ack_message_id,
	output logic        ack_is_duplicate,
	output logic        telemetry_new,
	output logic        node_known
);
	import rdas_pkg::*;
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SRCH = 2'd1;
	localparam logic [1:0] S_EXEC = 2'd2;
	cfg_t cfg;
	item_t it_q;
	res_t res_q;
	logic [1:0] state_q;
	logic ovalid_q;
	logic [1:0] status_q;
	logic [31:0] status_until_q, queued_at_q, earliest_at_q, sent_at_q, aux_since_q;
	logic pending_q, sending_q, saw_busy_q, aux_sv_q, pend_dup_q, known_q;
	logic [15:0] pend_node_q;
	logic [31:0] pend_msg_q;
	logic srch_start, srch_done, srch_dup, hist_wr;
	logic accept;
	assign pready = 1'b1;
	assign accept = in_valid && !in_stall;
	assign in_stall = state_q != S_IDLE || ovalid_q;
	rdas_cfg u_cfg (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .cfg(cfg)
	);
	logic pkt_ok;
	assign pkt_ok = it_q.func == FUNC_PKT && it_q.node_id == cfg.expected_node_id
		&& it_q.message_id != 32'd0
		&& (it_q.valid_flags & ~cfg.known_flags_mask) == 8'd0;
	assign srch_start = state_q == S_EXEC && pkt_ok;
	assign hist_wr = state_q == S_SRCH && srch_done && !srch_dup;
	rdas_hist #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_hist (
		.clk(clk), .arst_n(arst_n), .start(srch_start), .node(it_q.node_id),
		.msg(it_q.message_id), .wr(hist_wr), .done(srch_done), .dup(srch_dup)
	);
	// next-state evaluation of one transaction
	logic [1:0] n_status;
	logic [31:0] n_until, n_queued, n_earliest, n_sent, n_auxs;
	logic n_pend, n_send, n_busy, n_auxv, n_pdup, n_known, sent, tele;
	logic [15:0] n_pnode;
	logic [31:0] n_pmsg;
	logic [3:0] ev;
	logic rdy;
	logic [31:0] t, el_sent, el_q, e_err;
	always_comb begin
		n_status = status_q; n_until = status_until_q; n_queued = queued_at_q;
		n_earliest = earliest_at_q; n_sent = sent_at_q; n_auxs = aux_since_q;
		n_pend = pending_q; n_send = sending_q; n_busy = saw_busy_q; n_auxv = aux_sv_q;
		n_pdup = pend_dup_q; n_known = known_q; n_pnode = pend_node_q; n_pmsg = pend_msg_q;
		sent = 1'b0; tele = 1'b0; ev = EV_NONE; rdy = 1'b0;
		t = it_q.now;
		el_sent = t - sent_at_q;
		el_q = t - queued_at_q;
		e_err = t + {16'd0, cfg.err_hold_ms};
		case (it_q.func)
			FUNC_PKT: begin
				if (it_q.node_id != cfg.expected_node_id || it_q.message_id == 32'd0) begin
					n_status = ST_ERROR; n_until = e_err; ev = EV_BAD_ID;
				end else if ((it_q.valid_flags & ~cfg.known_flags_mask) != 8'd0) begin
					n_status = ST_ERROR; n_until = e_err; ev = EV_BAD_FLAGS;
				end else begin
					if (!srch_dup) begin tele = 1'b1; n_known = 1'b1; end
					ev = srch_dup ? EV_DUPLICATE : EV_ACCEPTED;
					n_status = ST_RECEIVING;
					n_until = t + {16'd0, cfg.rx_hold_ms};
					n_pnode = it_q.node_id; n_pmsg = it_q.message_id; n_pdup = srch_dup;
					n_pend = 1'b1; n_queued = t;
					n_earliest = t + {16'd0, cfg.rx_hold_ms};
				end
			end
			FUNC_PERR: begin
				n_status = ST_ERROR; n_until = e_err; ev = EV_PARSE_INV;
			end
			FUNC_TICK: begin
				if (sending_q) begin
					if (!it_q.aux_high) begin n_busy = 1'b1; n_auxv = 1'b0; end
					if (!it_q.aux_high) n_auxv = 1'b0;
					else if (!n_auxv) begin n_auxv = 1'b1; n_auxs = t; end
					else rdy = (t - n_auxs) >= {16'd0, cfg.aux_settle_ms};
					if (rdy && (n_busy || el_sent >= {16'd0, cfg.tx_min_ms})) begin
						n_send = 1'b0;
						n_until = t + {16'd0, cfg.ack_hold_ms};
						ev = EV_ACK_DONE;
					end else if (el_sent >= {16'd0, cfg.tx_limit_ms}) begin
						n_send = 1'b0; n_status = ST_ERROR; n_until = e_err;
						ev = EV_TX_TIMEOUT;
					end
				end
				if (n_pend && !n_send && reached(t, n_earliest)) begin
					rdy = 1'b0;
					if (!it_q.aux_high) n_auxv = 1'b0;
					else if (!n_auxv) begin n_auxv = 1'b1; n_auxs = t; end
					else rdy = (t - n_auxs) >= {16'd0, cfg.aux_settle_ms};
					if (!rdy) begin
						if (el_q >= {16'd0, cfg.tx_limit_ms}) begin
							n_pend = 1'b0; n_status = ST_ERROR; n_until = e_err;
							ev = EV_AUX_FAIL;
						end
					end else if (!it_q.tx_complete) begin
						n_pend = 1'b0; n_status = ST_ERROR; n_until = e_err;
						ev = EV_SHORT_WR;
					end else begin
						n_pend = 1'b0; n_send = 1'b1; n_busy = 1'b0; n_sent = t;
						n_auxv = 1'b0; n_status = ST_ACKING;
						n_until = t + {16'd0, cfg.ack_hold_ms};
						sent = 1'b1; ev = EV_ACK_SENT;
					end
				end
				if (!n_pend && !n_send && n_status != ST_STANDBY && reached(t, n_until))
					n_status = ST_STANDBY;
			end
			default: ;
		endcase
	end
	logic finish;
	assign finish = (state_q == S_EXEC && !pkt_ok) || (state_q == S_SRCH && srch_done);
	always_ff @(posedge clk) begin
		if (accept) it_q <= '{func, now, node_id, message_id, valid_flags, aux_high,
			tx_complete};
		if (finish) begin
			res_q.link_status <= n_status;
			res_q.event_res <= ev;
			res_q.ack_send <= sent;
			res_q.ack_node_id <= sent ? n_pnode : 16'd0;
			res_q.ack_message_id <= sent ? n_pmsg : 32'd0;
			res_q.ack_is_duplicate <= sent && n_pdup;
			res_q.telemetry_new <= tele;
			res_q.node_known <= n_known;
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; ovalid_q <= 1'b0;
			status_q <= ST_STANDBY; status_until_q <= '0; queued_at_q <= '0;
			earliest_at_q <= '0; sent_at_q <= '0; aux_since_q <= '0;
			pending_q <= 1'b0; sending_q <= 1'b0; saw_busy_q <= 1'b0; aux_sv_q <= 1'b0;
			pend_dup_q <= 1'b0; known_q <= 1'b0; pend_node_q <= '0; pend_msg_q <= '0;
		end else begin
			if (out_valid && !out_stall) ovalid_q <= 1'b0;
			case (state_q)
				S_IDLE: if (accept) state_q <= S_EXEC;
				S_EXEC: if (pkt_ok) state_q <= S_SRCH;
				S_SRCH: ;
				default: state_q <= S_IDLE;
			endcase
			if (finish) begin
				state_q <= S_IDLE; ovalid_q <= 1'b1;
				status_q <= n_status; status_until_q <= n_until; queued_at_q <= n_queued;
				earliest_at_q <= n_earliest; sent_at_q <= n_sent; aux_since_q <= n_auxs;
				pending_q <= n_pend; sending_q <= n_send; saw_busy_q <= n_busy;
				aux_sv_q <= n_auxv; pend_dup_q <= n_pdup; known_q <= n_known;
				pend_node_q <= n_pnode; pend_msg_q <= n_pmsg;
			end
		end
	end
	assign out_valid = ovalid_q;
	assign link_status = res_q.link_status;
	assign event_res = res_q.event_res;
	assign ack_send = res_q.ack_send;
	assign ack_node_id = res_q.ack_node_id;
	assign ack_message_id = res_q.ack_message_id;
	assign ack_is_duplicate = res_q.ack_is_duplicate;
	assign telemetry_new = res_q.telemetry_new;
	assign node_known = res_q.node_known;

	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> in_stall) else $error("accept while busy");
	a_hist_wr: assert property (@(posedge clk) disable iff (!arst_n)
		hist_wr |-> state_q == S_SRCH && pkt_ok) else $error("bad history write");
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		finish |=> out_valid) else $error("result lost");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(event_res) && $stable(link_status))
		else $error("result changed while stalled");
endmodule

@@ rtl/core/rdas_ram.sv @@
// Generic single-port-write, single-read RAM with registered read data.
module rdas_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

@@ rtl/core/rdas_cfg.sv @@
// APB configuration register file.
module rdas_cfg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output rdas_pkg::cfg_t     cfg
);
	import rdas_pkg::*;
	cfg_t cfg_q;
	logic [2:0] idx;
	assign idx = paddr[4:2];
	assign cfg = cfg_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.expected_node_id <= 16'd1;
			cfg_q.known_flags_mask <= 8'd31;
			cfg_q.rx_hold_ms <= 16'd500;
			cfg_q.ack_hold_ms <= 16'd500;
			cfg_q.err_hold_ms <= 16'd1000;
			cfg_q.tx_min_ms <= 16'd50;
			cfg_q.tx_limit_ms <= 16'd2000;
			cfg_q.aux_settle_ms <= 16'd5;
		end else if (psel && penable && pwrite) begin
			case (idx)
				REG_NODE: cfg_q.expected_node_id <= pwdata[15:0];
				REG_FLAGS: cfg_q.known_flags_mask <= pwdata[7:0];
				REG_RXDISP: cfg_q.rx_hold_ms <= pwdata[15:0];
				REG_ACKDISP: cfg_q.ack_hold_ms <= pwdata[15:0];
				REG_ERRDISP: cfg_q.err_hold_ms <= pwdata[15:0];
				REG_TXMIN: cfg_q.tx_min_ms <= pwdata[15:0];
				REG_TXTMO: cfg_q.tx_limit_ms <= pwdata[15:0];
				REG_AUXST: cfg_q.aux_settle_ms <= pwdata[15:0];
				default: ;
			endcase
		end
	end
	always_comb begin
		case (idx)
			REG_NODE: prdata = {16'd0, cfg_q.expected_node_id};
			REG_FLAGS: prdata = {24'd0, cfg_q.known_flags_mask};
			REG_RXDISP: prdata = {16'd0, cfg_q.rx_hold_ms};
			REG_ACKDISP: prdata = {16'd0, cfg_q.ack_hold_ms};
			REG_ERRDISP: prdata = {16'd0, cfg_q.err_hold_ms};
			REG_TXMIN: prdata = {16'd0, cfg_q.tx_min_ms};
			REG_TXTMO: prdata = {16'd0, cfg_q.tx_limit_ms};
			REG_AUXST: prdata = {16'd0, cfg_q.aux_settle_ms};
			default: prdata = 32'd0;
		endcase
	end
endmodule

@@ rtl/core/rdas_hist.sv @@
// History search: walks the node/message memory one entry per cycle.
module rdas_hist #(
	parameter int HISTORY_DEPTH = rdas_pkg::HIST_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [15:0] node,
	input  logic [31:0] msg,
	input  logic        wr,
	output logic        done,
	output logic        dup
);
	import rdas_pkg::*;
	localparam int AW = $clog2(HISTORY_DEPTH > 1 ? HISTORY_DEPTH : 2);
	localparam int CW = $clog2(HISTORY_DEPTH + 1);
	logic [HISTORY_DEPTH-1:0] valid_q;
	logic [AW-1:0] ptr_q, raddr_q, rd_idx_s1;
	logic [CW-1:0] cnt_q;
	logic busy_q, rd_s1, dup_q;
	logic [47:0] rdata;
	rdas_ram #(.WIDTH(48), .DEPTH(HISTORY_DEPTH)) u_mem (
		.clk(clk), .we(wr), .waddr(ptr_q), .wdata({node, msg}),
		.raddr(raddr_q), .rdata(rdata)
	);
	logic hit;
	assign hit = rd_s1 && valid_q[rd_idx_s1] && rdata == {node, msg};
	assign done = busy_q && cnt_q == CW'(HISTORY_DEPTH) && !rd_s1;
	assign dup = dup_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			ptr_q <= '0;
			raddr_q <= '0;
			rd_idx_s1 <= '0;
			cnt_q <= '0;
			busy_q <= 1'b0;
			rd_s1 <= 1'b0;
			dup_q <= 1'b0;
		end else begin
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
				raddr_q <= '0;
				rd_s1 <= 1'b0;
				dup_q <= 1'b0;
			end else if (busy_q) begin
				if (hit) dup_q <= 1'b1;
				if (cnt_q != CW'(HISTORY_DEPTH)) begin
					rd_s1 <= 1'b1;
					rd_idx_s1 <= raddr_q;
					raddr_q <= raddr_q + AW'(1);
					cnt_q <= cnt_q + CW'(1);
				end else begin
					rd_s1 <= 1'b0;
				end
				if (done) busy_q <= 1'b0;
			end
			if (wr) begin
				valid_q[ptr_q] <= 1'b1;
				ptr_q <= (ptr_q == AW'(HISTORY_DEPTH - 1)) ? '0 : ptr_q + AW'(1);
			end
		end
	end
endmodule
